[rtl/core/limit_order_book_matcher_defines.svh]
// assertion helpers shared by the matcher modules
`ifndef LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH

// condition that holds on every clock edge outside reset
`define LOBM_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define LOBM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/lobm_pkg.sv]
`default_nettype none
package lobm_pkg;

   localparam int BOOK_ENTRIES = 32;
   localparam int PRICE_BITS   = 24;
   localparam int IDX_W        = $clog2(BOOK_ENTRIES);
   localparam int CNT_W        = $clog2(BOOK_ENTRIES + 1);
   localparam int RES_DEPTH    = BOOK_ENTRIES + 1;
   localparam int RES_AW       = $clog2(RES_DEPTH);
   localparam int RES_W        = $clog2(RES_DEPTH + 1);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      KIND_FILL      = 3'd0,
      KIND_RESTED    = 3'd1,
      KIND_FILLED    = 3'd2,
      KIND_CANCELLED = 3'd3,
      KIND_NOT_FOUND = 3'd4,
      KIND_REJECTED  = 3'd5
   } kind_type;

   typedef struct packed {
      logic        operation;
      logic [31:0] order_ref;
      logic        side;
      logic [23:0] limit_price;
      logic [31:0] order_quantity;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] buy_order_id;
      logic [31:0] sell_order_id;
      logic [23:0] trade_price;
      logic [31:0] trade_quantity;
      logic [5:0]  resting_bids;
      logic [5:0]  resting_asks;
      logic        last;
   } rsp_type;

   // classified command handed from front to engine
   typedef struct packed {
      logic                  is_cancel;
      logic [31:0]           id;
      logic                  side;
      logic                  rside;
      logic [PRICE_BITS-1:0] limit;
      logic [31:0]           qty;
   } cmd_type;

   // one result record before the book counts are known
   typedef struct packed {
      kind_type    kind;
      logic [31:0] buy_id;
      logic [31:0] sell_id;
      logic [23:0] price;
      logic [31:0] qty;
   } rec_type;

   typedef struct packed {
      logic              en;
      logic [RES_AW-1:0] addr;
      rec_type           rec;
   } res_wr_type;

   typedef struct packed {
      logic             go;
      logic [RES_W-1:0] n;
      logic [CNT_W-1:0] bids;
      logic [CNT_W-1:0] asks;
   } drain_type;

endpackage
`default_nettype wire

[rtl/core/lobm_front.sv]
`default_nettype none
module lobm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  lobm_pkg::req_type   req_item,
   input  logic                pop,
   output logic                cmd_valid,
   output lobm_pkg::cmd_type   cmd
);
   import lobm_pkg::*;

   cmd_type            queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic               push, pop_fire;
   cmd_type            cls;

   assign busy      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push      = start && !busy;
   assign pop_fire  = pop && cmd_valid;

   // classify the incoming beat
   always_comb begin
      cls.is_cancel = req_item.operation;
      cls.id        = req_item.order_ref;
      cls.side      = req_item.side;
      cls.rside     = ~req_item.side;
      cls.limit     = PRICE_BITS'(req_item.limit_price);
      cls.qty       = req_item.order_quantity;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
         end
         if (pop_fire) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop_fire) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop_fire && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

endmodule
`default_nettype wire

[rtl/core/lobm_engine.sv]
`default_nettype none
`include "limit_order_book_matcher_defines.svh"
module lobm_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  lobm_pkg::cmd_type    cmd,
   output logic                 pop,
   output lobm_pkg::res_wr_type res_wr,
   output lobm_pkg::drain_type  drain,
   input  logic                 drain_done
);
   import lobm_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_MATCH  = 5'b00100,
      S_FINISH = 5'b01000,
      S_DRAIN  = 5'b10000
   } eng_state_type;

   eng_state_type          state_ff;
   logic [BOOK_ENTRIES-1:0] entry_valid_ff;
   logic [BOOK_ENTRIES-1:0] entry_side_ff;
   logic [31:0]            entry_id_ff    [BOOK_ENTRIES];
   logic [PRICE_BITS-1:0]  entry_price_ff [BOOK_ENTRIES];
   logic [31:0]            entry_rem_ff   [BOOK_ENTRIES];
   logic [63:0]            entry_arr_ff   [BOOK_ENTRIES];

   cmd_type                cur_ff;
   logic [31:0]            rem_ff;
   logic [63:0]            stamp_ff, arrival_ff;
   logic [IDX_W-1:0]       scan_idx_ff, best_idx_ff;
   logic                   best_found_ff;
   logic [PRICE_BITS-1:0]  best_price_ff;
   logic [63:0]            best_arr_ff;
   logic [31:0]            best_id_ff, best_rem_ff;
   logic [RES_W-1:0]       wr_cnt_ff;
   logic [CNT_W-1:0]       bids_ff, asks_ff;

   logic                   id_hit, hit_side, free_found;
   logic [IDX_W-1:0]       hit_idx, free_idx;
   logic                   cand, better, crosses;
   logic [31:0]            q;

   // id lookup and free entry, lowest index wins
   always_comb begin
      id_hit     = 1'b0;
      hit_side   = 1'b0;
      hit_idx    = '0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = BOOK_ENTRIES - 1; i >= 0; i--) begin
         if (entry_valid_ff[i] && entry_id_ff[i] == cmd.id) begin
            id_hit   = 1'b1;
            hit_side = entry_side_ff[i];
            hit_idx  = IDX_W'(i);
         end
         if (!entry_valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // scan step and match test
   always_comb begin
      cand = entry_valid_ff[scan_idx_ff] && (entry_side_ff[scan_idx_ff] == cur_ff.rside);
      if (!best_found_ff) begin
         better = 1'b1;
      end else if (entry_price_ff[scan_idx_ff] != best_price_ff) begin
         better = cur_ff.rside ? (entry_price_ff[scan_idx_ff] < best_price_ff)
                               : (entry_price_ff[scan_idx_ff] > best_price_ff);
      end else begin
         better = entry_arr_ff[scan_idx_ff] < best_arr_ff;
      end
      crosses = best_found_ff && (wr_cnt_ff < RES_W'(BOOK_ENTRIES)) &&
                (cur_ff.side ? !(cur_ff.limit > best_price_ff)
                             : !(cur_ff.limit < best_price_ff));
      q = (rem_ff < best_rem_ff) ? rem_ff : best_rem_ff;
   end

   assign pop = (state_ff == S_IDLE) && cmd_valid;

   // result record for this cycle
   always_comb begin
      res_wr.en          = 1'b0;
      res_wr.addr        = wr_cnt_ff[RES_AW-1:0];
      res_wr.rec.kind    = KIND_FILLED;
      res_wr.rec.buy_id  = cur_ff.id;
      res_wr.rec.sell_id = '0;
      res_wr.rec.price   = '0;
      res_wr.rec.qty     = '0;
      case (state_ff)
         S_IDLE: begin
            res_wr.addr       = '0;
            res_wr.rec.buy_id = cmd.id;
            if (cmd_valid) begin
               if (cmd.is_cancel) begin
                  res_wr.en       = 1'b1;
                  res_wr.rec.kind = id_hit ? KIND_CANCELLED : KIND_NOT_FOUND;
               end else if (id_hit) begin
                  res_wr.en       = 1'b1;
                  res_wr.rec.kind = KIND_REJECTED;
                  res_wr.rec.qty  = cmd.qty;
               end
            end
         end
         S_MATCH: begin
            if (crosses) begin
               res_wr.en          = 1'b1;
               res_wr.rec.kind    = KIND_FILL;
               res_wr.rec.buy_id  = cur_ff.side ? best_id_ff : cur_ff.id;
               res_wr.rec.sell_id = cur_ff.side ? cur_ff.id : best_id_ff;
               res_wr.rec.price   = 24'(best_price_ff);
               res_wr.rec.qty     = q;
            end
         end
         S_FINISH: begin
            res_wr.en = 1'b1;
            if (rem_ff == '0) begin
               res_wr.rec.kind = KIND_FILLED;
            end else begin
               res_wr.rec.kind = free_found ? KIND_RESTED : KIND_REJECTED;
               res_wr.rec.qty  = rem_ff;
            end
         end
         default: begin
            res_wr.en = 1'b0;
         end
      endcase
   end

   assign drain.go   = (state_ff == S_DRAIN);
   assign drain.n    = wr_cnt_ff;
   assign drain.bids = bids_ff;
   assign drain.asks = asks_ff;

   // entry payload, no reset needed
   always_ff @(posedge clock) begin
      case (state_ff)
         S_MATCH: begin
            if (crosses) begin
               entry_rem_ff[best_idx_ff] <= best_rem_ff - q;
            end
         end
         S_FINISH: begin
            if (rem_ff != '0 && free_found) begin
               entry_id_ff[free_idx]    <= cur_ff.id;
               entry_side_ff[free_idx]  <= cur_ff.side;
               entry_price_ff[free_idx] <= cur_ff.limit;
               entry_rem_ff[free_idx]   <= rem_ff;
               entry_arr_ff[free_idx]   <= stamp_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // working registers of the current command
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            cur_ff        <= cmd;
            rem_ff        <= cmd.qty;
            stamp_ff      <= arrival_ff;
            scan_idx_ff   <= '0;
            best_found_ff <= 1'b0;
         end
         S_SCAN: begin
            scan_idx_ff <= scan_idx_ff + IDX_W'(1);
            if (cand && better) begin
               best_found_ff <= 1'b1;
               best_idx_ff   <= scan_idx_ff;
               best_price_ff <= entry_price_ff[scan_idx_ff];
               best_arr_ff   <= entry_arr_ff[scan_idx_ff];
               best_id_ff    <= entry_id_ff[scan_idx_ff];
               best_rem_ff   <= entry_rem_ff[scan_idx_ff];
            end
         end
         S_MATCH: begin
            // remainder only shrinks on an actual fill
            if (crosses) begin
               rem_ff <= rem_ff - q;
            end
            scan_idx_ff   <= '0;
            best_found_ff <= 1'b0;
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_valid_ff <= '0;
         arrival_ff     <= '0;
         wr_cnt_ff      <= '0;
         bids_ff        <= '0;
         asks_ff        <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  if (cmd.is_cancel || id_hit) begin
                     wr_cnt_ff <= RES_W'(1);
                     state_ff  <= S_DRAIN;
                     if (cmd.is_cancel && id_hit) begin
                        entry_valid_ff[hit_idx] <= 1'b0;
                        if (hit_side) begin
                           asks_ff <= asks_ff - CNT_W'(1);
                        end else begin
                           bids_ff <= bids_ff - CNT_W'(1);
                        end
                     end
                  end else begin
                     arrival_ff <= arrival_ff + 64'd1;
                     wr_cnt_ff  <= '0;
                     state_ff   <= (cmd.qty == '0) ? S_FINISH : S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (scan_idx_ff == IDX_W'(BOOK_ENTRIES - 1)) begin
                  state_ff <= S_MATCH;
               end
            end
            S_MATCH: begin
               if (!crosses) begin
                  state_ff <= S_FINISH;
               end else begin
                  wr_cnt_ff <= wr_cnt_ff + RES_W'(1);
                  if (best_rem_ff == q) begin
                     entry_valid_ff[best_idx_ff] <= 1'b0;
                     if (cur_ff.rside) begin
                        asks_ff <= asks_ff - CNT_W'(1);
                     end else begin
                        bids_ff <= bids_ff - CNT_W'(1);
                     end
                  end
                  state_ff <= (rem_ff == q) ? S_FINISH : S_SCAN;
               end
            end
            S_FINISH: begin
               wr_cnt_ff <= wr_cnt_ff + RES_W'(1);
               state_ff  <= S_DRAIN;
               if (rem_ff != '0 && free_found) begin
                  entry_valid_ff[free_idx] <= 1'b1;
                  if (cur_ff.side) begin
                     asks_ff <= asks_ff + CNT_W'(1);
                  end else begin
                     bids_ff <= bids_ff + CNT_W'(1);
                  end
               end
            end
            S_DRAIN: begin
               if (drain_done) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `LOBM_ASSERT_ALWAYS(a_count_match, $countones(entry_valid_ff) == int'(bids_ff) + int'(asks_ff), "side counts disagree with valid entries")
   `LOBM_ASSERT_ALWAYS(a_res_bound, wr_cnt_ff <= RES_W'(RES_DEPTH), "result buffer overrun")
   `LOBM_ASSERT_NEXT(a_idle_after_done, state_ff == S_DRAIN && drain_done, state_ff == S_IDLE, "engine stuck after drain")

endmodule
`default_nettype wire

[rtl/core/lobm_resbuf.sv]
`default_nettype none
`include "limit_order_book_matcher_defines.svh"
module lobm_resbuf (
   input  logic                 clock,
   input  logic                 reset,
   input  lobm_pkg::res_wr_type res_wr,
   input  lobm_pkg::drain_type  drain,
   output logic                 drain_done,
   output logic                 rsp_strobe,
   output lobm_pkg::rsp_type    rsp_item
);
   import lobm_pkg::*;

   rec_type            res_mem_ff [RES_DEPTH];
   rec_type            rd_data_ff;
   logic [RES_AW-1:0]  rd_ptr_ff;
   logic               strobe_ff, last_ff;
   logic [CNT_W-1:0]   bids_ff, asks_ff;

   assign drain_done = drain.go && (RES_W'(rd_ptr_ff) == drain.n - RES_W'(1));

   always_ff @(posedge clock) begin
      if (res_wr.en) begin
         res_mem_ff[res_wr.addr] <= res_wr.rec;
      end
      if (drain.go) begin
         rd_data_ff <= res_mem_ff[rd_ptr_ff];
         last_ff    <= drain_done;
         bids_ff    <= drain.bids;
         asks_ff    <= drain.asks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= drain.go;
         if (drain_done) begin
            rd_ptr_ff <= '0;
         end else if (drain.go) begin
            rd_ptr_ff <= rd_ptr_ff + RES_AW'(1);
         end
      end
   end

   assign rsp_strobe              = strobe_ff;
   assign rsp_item.kind           = rd_data_ff.kind;
   assign rsp_item.buy_order_id   = rd_data_ff.buy_id;
   assign rsp_item.sell_order_id  = rd_data_ff.sell_id;
   assign rsp_item.trade_price    = rd_data_ff.price;
   assign rsp_item.trade_quantity = rd_data_ff.qty;
   assign rsp_item.resting_bids   = 6'(bids_ff);
   assign rsp_item.resting_asks   = 6'(asks_ff);
   assign rsp_item.last           = last_ff;

   `LOBM_ASSERT_NEXT(a_last_follows_done, drain_done, rsp_strobe && rsp_item.last, "closing beat missing")
   `LOBM_ASSERT_ALWAYS(a_ptr_bound, RES_W'(rd_ptr_ff) < RES_W'(RES_DEPTH), "drain pointer out of range")

endmodule
`default_nettype wire

[rtl/core/limit_order_book_matcher.sv]
// cancel or duplicate reject: the engine goes from idle to drain and sends a single status beat
// add: scan all entries, then match, per round; then a finish step and one beat per cycle
// one item in work at a time; each fill that leaves a remainder starts a new scan round
// the per-entry scan of the best-price search sets the work time; a 2-deep queue fronts it
// reset: synchronous, clears the book, arrival counter, queue and output strobe
// results cannot be stalled: every beat is shown for exactly one cycle
`default_nettype none
module limit_order_book_matcher (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lobm_pkg::req_type req_item,
   output logic              rsp_strobe,
   output lobm_pkg::rsp_type rsp_item
);
   import lobm_pkg::*;

   // front to engine: classified command queue
   logic       cmd_valid;
   logic       pop;
   cmd_type    cmd;

   // engine to result buffer: record writes and drain control
   res_wr_type res_wr;
   drain_type  drain;
   logic       drain_done;

   // front: accepts beats while the queue has room
   lobm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .pop       (pop),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   // engine: id lookup, best-price scan, fills, resting and cancels
   lobm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .pop        (pop),
      .res_wr     (res_wr),
      .drain      (drain),
      .drain_done (drain_done)
   );

   // result buffer: holds the records until the final book counts are known
   lobm_resbuf u_resbuf (
      .clock      (clock),
      .reset      (reset),
      .res_wr     (res_wr),
      .drain      (drain),
      .drain_done (drain_done),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
`default_nettype wire
